### src/sts_pkg.sv
package sts_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned TagW = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [2:0] {
    PH_RECT    = 3'd0,
    PH_SKIPHDR = 3'd1,
    PH_TAGHDR  = 3'd2,
    PH_LONGLEN = 3'd3,
    PH_BODY    = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_BITMAP    = 2'd0,
    EV_END       = 2'd1,
    EV_TRUNCATED = 2'd2
  } event_t;

  localparam logic [TagW-1:0] TagEnd    = 10'd0;
  localparam logic [TagW-1:0] TagShape1 = 10'd2;
  localparam logic [TagW-1:0] TagShape2 = 10'd22;
  localparam logic [TagW-1:0] TagShape3 = 10'd32;
  localparam logic [TagW-1:0] TagJpeg2  = 10'd21;
  localparam logic [TagW-1:0] TagJpeg3  = 10'd35;

  localparam logic [5:0] ShortLenLong = 6'h3f;
  localparam logic [4:0] FrameTrailBytes = 5'd4;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
  } sts_byte_t;

  typedef struct packed {
    logic             shapes_seen;
    logic [WordW-1:0] body_length;
    logic [WordW-1:0] body_offset;
    logic [TagW-1:0]  tag_code;
    event_t           event_res;
  } sts_result_t;

  function automatic logic is_bitmap(input logic [TagW-1:0] code);
    return (code == TagJpeg2) || (code == TagJpeg3);
  endfunction

  function automatic logic is_shape(input logic [TagW-1:0] code);
    return (code == TagShape1) || (code == TagShape2) || (code == TagShape3);
  endfunction

endpackage

### src/sts_in_stage.sv
module sts_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sts_pkg::sts_byte_t in_item,
  input  logic              advance_ready,
  output logic              item_valid,
  output logic              advance,
  output sts_pkg::sts_byte_t item
);
  import sts_pkg::*;

  logic      valid;
  sts_byte_t held;

  assign advance    = valid && advance_ready;
  assign in_ready   = !valid || advance_ready;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

endmodule

### src/sts_parser.sv
module sts_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  sts_pkg::sts_byte_t  item,
  output logic                res_valid,
  output sts_pkg::sts_result_t res
);
  import sts_pkg::*;

  phase_t            phase, phase_next;
  logic [WordW-1:0]  skip_remaining, skip_remaining_next;
  logic [WordW-1:0]  header_shift, header_shift_next;
  logic [1:0]        header_bytes_got, header_bytes_got_next;
  logic [TagW-1:0]   current_tag, current_tag_next;
  logic              shape_flag, shape_flag_next;
  logic [WordW-1:0]  byte_position, byte_position_next;
  logic [WordW-1:0]  body_start, body_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RECT;
      skip_remaining   <= '0;
      header_shift     <= '0;
      header_bytes_got <= '0;
      current_tag      <= '0;
      shape_flag       <= 1'b0;
      byte_position    <= '0;
      body_start       <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      skip_remaining   <= skip_remaining_next;
      header_shift     <= header_shift_next;
      header_bytes_got <= header_bytes_got_next;
      current_tag      <= current_tag_next;
      shape_flag       <= shape_flag_next;
      byte_position    <= byte_position_next;
      body_start       <= body_start_next;
    end
  end

  always_comb begin
    logic [DataW-1:0] b;
    logic [15:0]      hdr;
    logic [TagW-1:0]  code;
    logic [5:0]       slen;
    logic [5:0]       half_bits;
    logic [WordW-1:0] dec;
    logic             start_body;
    logic [WordW-1:0] start_len;
    logic             finish;
    logic             emit;

    b          = item.data_byte;
    hdr        = 16'd0;
    code       = '0;
    slen       = '0;
    half_bits  = '0;
    dec        = skip_remaining - WordW'(1);
    start_body = 1'b0;
    start_len  = '0;
    finish     = 1'b0;
    emit       = 1'b0;

    phase_next            = phase;
    skip_remaining_next   = skip_remaining;
    header_shift_next     = header_shift;
    header_bytes_got_next = header_bytes_got;
    current_tag_next      = current_tag;
    shape_flag_next       = shape_flag;
    byte_position_next    = byte_position + WordW'(1);
    body_start_next       = body_start;
    res                   = '{shapes_seen: 1'b0, body_length: '0, body_offset: '0,
                              tag_code: '0, event_res: EV_END};

    unique case (phase)
      PH_RECT: begin
        half_bits           = ({1'b0, b[7:3]} + 6'd1) >> 1;
        skip_remaining_next = WordW'(half_bits) + WordW'(FrameTrailBytes);
        phase_next          = PH_SKIPHDR;
      end
      PH_SKIPHDR: begin
        skip_remaining_next = dec;
        if (dec == '0) begin
          phase_next            = PH_TAGHDR;
          header_shift_next     = '0;
          header_bytes_got_next = '0;
        end
      end
      PH_TAGHDR: begin
        if (!header_bytes_got[0]) begin
          header_shift_next     = header_shift | WordW'(b);
          header_bytes_got_next = header_bytes_got + 2'd1;
        end else begin
          hdr                   = {b, header_shift[7:0]};
          code                  = hdr[15:6];
          slen                  = hdr[5:0];
          current_tag_next      = code;
          header_shift_next     = '0;
          header_bytes_got_next = '0;
          if (code == TagEnd) begin
            emit          = 1'b1;
            res.event_res = EV_END;
            phase_next    = PH_DONE;
          end else begin
            if (is_shape(code)) begin
              shape_flag_next = 1'b1;
            end
            if (slen == ShortLenLong) begin
              phase_next = PH_LONGLEN;
            end else begin
              start_body = 1'b1;
              start_len  = WordW'(slen);
            end
          end
        end
      end
      PH_LONGLEN: begin
        header_shift_next     = header_shift | (WordW'(b) << {header_bytes_got, 3'b000});
        header_bytes_got_next = header_bytes_got + 2'd1;
        if (header_bytes_got == 2'd3) begin
          header_bytes_got_next = '0;
          start_body            = 1'b1;
          start_len             = header_shift_next;
        end
      end
      PH_BODY: begin
        skip_remaining_next = dec;
        if (dec == '0) begin
          finish = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (start_body) begin
      body_start_next     = byte_position + WordW'(1);
      header_shift_next   = start_len;
      skip_remaining_next = start_len;
      phase_next          = PH_BODY;
      if (start_len == '0) begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      if (is_bitmap(current_tag_next)) begin
        emit            = 1'b1;
        res.event_res   = EV_BITMAP;
        res.tag_code    = current_tag_next;
        res.body_offset = body_start_next;
        res.body_length = header_shift_next;
        phase_next      = PH_DONE;
      end else begin
        phase_next            = PH_TAGHDR;
        header_shift_next     = '0;
        header_bytes_got_next = '0;
      end
    end

    res.shapes_seen = shape_flag_next;

    if (item.last_byte) begin
      if (!emit && phase_next != PH_DONE) begin
        emit          = 1'b1;
        res.event_res = EV_TRUNCATED;
      end
      phase_next            = PH_RECT;
      skip_remaining_next   = '0;
      header_shift_next     = '0;
      header_bytes_got_next = '0;
      current_tag_next      = '0;
      shape_flag_next       = 1'b0;
      byte_position_next    = '0;
      body_start_next       = '0;
    end

    res_valid = advance && emit;
  end

endmodule

### src/sts_out_stage.sv
module sts_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sts_pkg::sts_result_t load_res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sts_pkg::sts_result_t out_res
);
  import sts_pkg::*;

  logic        valid;
  sts_result_t held;

  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_res;
    end
  end

endmodule

### src/swf_tag_stream_scanner_unit.sv
// Channel   Direction  Transaction      Fields
// s_axis    in         one stream byte  tdata: data_byte; tlast: last_byte
// m_axis    out        one report       tuser: event_res; tdata: tag_code, body_offset,
//                                               body_length, shapes_seen
//
// One byte per cycle sustained while reports are taken; a report passes through the input
// register and then the report register after its byte is taken; the parser state
// updates once per byte between them.
// rst clears all control state; the parser rearms on every byte marked tlast.
// A stalled report holds the byte pipeline; one further byte is buffered meanwhile.
module swf_tag_stream_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [9:0] tag_code, [41:10] body_offset,
                                      // [73:42] body_length, [74] shapes_seen,
                                      // [79:75] zero
  output logic [1:0]  m_axis_tuser    // [1:0] event_res
);
  import sts_pkg::*;

  sts_byte_t   in_item;
  sts_byte_t   item;
  logic        item_valid;
  logic        advance;
  logic        can_load;
  logic        res_valid;
  sts_result_t res;
  sts_result_t out_res;

  assign in_item = '{data_byte: s_axis_tdata, last_byte: s_axis_tlast};

  sts_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_item      (in_item),
    .advance_ready(can_load),
    .item_valid   (item_valid),
    .advance      (advance),
    .item         (item)
  );

  sts_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  sts_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (res),
    .can_load (can_load),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  assign m_axis_tdata = {5'b00000, out_res.shapes_seen, out_res.body_length,
                         out_res.body_offset, out_res.tag_code};
  assign m_axis_tuser = out_res.event_res;

  a_non_bitmap_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.event_res != EV_BITMAP) |->
      (out_res.tag_code == '0 && out_res.body_offset == '0 && out_res.body_length == '0))
    else $error("end or truncation report carries tag data");

  a_bitmap_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.event_res == EV_BITMAP) |->
      (out_res.tag_code == TagJpeg2 || out_res.tag_code == TagJpeg3))
    else $error("bitmap report with non-bitmap tag code");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("buffered byte lost while report stalled");

endmodule
